// ===== rtl/slq_pkg.sv =====
package slq_pkg;

  // Queue geometry
  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int FLOOR_W = 8;
  localparam int OUT_W   = FLOOR_W + 1;

  // Request codes
  localparam logic [2:0] REQ_ENQ    = 3'd0;
  localparam logic [2:0] REQ_DEQ    = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_MARK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic load_req;  // capture the incoming transaction
    logic exec;      // apply the request to queue state
    logic walk;      // one step of the match walk
    logic load_out;  // move the result into the output register
  } slq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_go;    // request needs a walk over held slots
    logic walk_done;  // every held slot has been compared
    logic out_free;   // output register can take a result this cycle
  } slq_sts_t;

endpackage

// ===== rtl/slq_ctrl.sv =====
module slq_ctrl
  import slq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  slq_sts_t sts,
  output slq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.walk_go ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          cmd.walk  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/slq_datapath.sv =====
module slq_datapath
  import slq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  slq_cmd_t           cmd,
  output slq_sts_t           sts,
  input  logic [2:0]         in_req_type,
  input  logic [FLOOR_W-1:0] in_floor_num,
  input  logic               in_target_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [OUT_W-1:0]   out_floor,
  output logic               out_target,
  output logic               out_found,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic [OUT_W-1:0]   out_tail_floor
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [OUT_W-1:0] NONE     = '1;

  // Slot storage
  logic [FLOOR_W-1:0] floor_mem [DEPTH];
  logic               tgt_mem   [DEPTH];

  // Request capture
  logic [2:0]         req_r;
  logic [FLOOR_W-1:0] floor_r;
  logic               tgt_r;

  // Queue state
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic               has_r, has_nxt;
  logic [FLOOR_W-1:0] tail_floor_r, tail_floor_nxt;
  logic               acc_r, acc_nxt;
  logic               found_r, found_nxt;

  // Walk state
  logic [IDX_W-1:0]   walk_idx_r, walk_idx_nxt;
  logic               walk_iss_r, walk_iss_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               hit;

  // Memory ports
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [FLOOR_W-1:0] rd_floor_r;
  logic               rd_tgt_r;
  logic               fwr_en;
  logic               twr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               twr_data;

  // Output register
  logic               ovld_r;

  assign hit = cmp_vld_r && (rd_floor_r == floor_r);

  assign sts.walk_go   = has_r && ((req_r == REQ_MARK) || (req_r == REQ_SEARCH));
  assign sts.walk_done = !walk_iss_r && !cmp_vld_r;
  assign sts.out_free  = !ovld_r || !out_stall;

  // Request execution and walk sequencing
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    has_nxt        = has_r;
    tail_floor_nxt = tail_floor_r;
    acc_nxt        = acc_r;
    found_nxt      = found_r;
    walk_idx_nxt   = walk_idx_r;
    walk_iss_nxt   = walk_iss_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    fwr_en         = 1'b0;
    twr_en         = 1'b0;
    wr_addr        = tail_r;
    twr_data       = tgt_r;

    if (cmd.load_req) begin
      acc_nxt      = 1'b0;
      found_nxt    = 1'b0;
      cmp_vld_nxt  = 1'b0;
      walk_iss_nxt = 1'b0;
    end

    if (cmd.exec) begin
      case (req_r)
        REQ_ENQ: begin
          if (!has_r) begin
            head_nxt       = '0;
            tail_nxt       = '0;
            has_nxt        = 1'b1;
            wr_addr        = '0;
            fwr_en         = 1'b1;
            twr_en         = 1'b1;
            tail_floor_nxt = floor_r;
            acc_nxt        = 1'b1;
          end else if (tail_r != LAST_IDX) begin
            tail_nxt       = tail_r + 1'b1;
            wr_addr        = tail_r + 1'b1;
            fwr_en         = 1'b1;
            twr_en         = 1'b1;
            tail_floor_nxt = floor_r;
            acc_nxt        = 1'b1;
          end
        end
        REQ_DEQ: begin
          if (has_r) begin
            rd_en   = 1'b1;
            rd_addr = head_r;
            acc_nxt = 1'b1;
            if (head_r == tail_r) begin
              head_nxt = '0;
              tail_nxt = '0;
              has_nxt  = 1'b0;
            end else begin
              head_nxt = head_r + 1'b1;
            end
          end
        end
        REQ_CLEAR: begin
          head_nxt = '0;
          tail_nxt = '0;
          has_nxt  = 1'b0;
        end
        REQ_MARK, REQ_SEARCH: begin
          walk_idx_nxt = head_r;
          walk_iss_nxt = has_r;
        end
        default: ;
      endcase
    end

    // Walk: issue one read per cycle, compare the previous read
    if (cmd.walk) begin
      cmp_vld_nxt = walk_iss_r;
      cmp_idx_nxt = walk_idx_r;
      if (walk_iss_r) begin
        rd_en   = 1'b1;
        rd_addr = walk_idx_r;
        if (walk_idx_r == tail_r) begin
          walk_iss_nxt = 1'b0;
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end
      if (hit) begin
        found_nxt = 1'b1;
        if (req_r == REQ_MARK) begin
          twr_en   = 1'b1;
          wr_addr  = cmp_idx_r;
          twr_data = 1'b1;
        end
      end
    end
  end

  // Slot memories
  always_ff @(posedge clk) begin
    if (fwr_en) begin
      floor_mem[wr_addr] <= floor_r;
    end
    if (twr_en) begin
      tgt_mem[wr_addr] <= twr_data;
    end
    if (rd_en) begin
      rd_floor_r <= floor_mem[rd_addr];
      rd_tgt_r   <= tgt_mem[rd_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      has_r      <= 1'b0;
      walk_iss_r <= 1'b0;
      cmp_vld_r  <= 1'b0;
      ovld_r     <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      has_r      <= has_nxt;
      walk_iss_r <= walk_iss_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      if (cmd.load_out) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_req_type;
      floor_r <= in_floor_num;
      tgt_r   <= in_target_in;
    end
    tail_floor_r <= tail_floor_nxt;
    acc_r        <= acc_nxt;
    found_r      <= found_nxt;
    walk_idx_r   <= walk_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    if (cmd.load_out) begin
      out_accepted   <= acc_r;
      out_found      <= found_r;
      out_is_empty   <= !has_r;
      out_is_full    <= has_r && (tail_r == LAST_IDX);
      out_tail_floor <= has_r ? {1'b0, tail_floor_r} : NONE;
      if (req_r == REQ_DEQ) begin
        out_floor  <= acc_r ? {1'b0, rd_floor_r} : NONE;
        out_target <= acc_r && rd_tgt_r;
      end else begin
        out_floor  <= '0;
        out_target <= 1'b0;
      end
    end
  end

  assign out_valid = ovld_r;

endmodule

// ===== rtl/searchable_linear_queue.sv =====
// Searchable linear queue of floor requests.
// Input channel: in_valid/in_stall with in_req_type, in_floor_num, in_target_in.
// One request is taken at a time; in_stall is high from acceptance until
// its result has been moved into the output register.
// Result channel: out_valid/out_stall with one result per request. The
// output register holds a result while out_stall is high; the next request
// is accepted meanwhile and waits for the register before finishing.
// Enqueue, dequeue, clear, unknown codes and a mark or search of an empty
// queue go from capture through execute to the output register; mark and
// search of a held queue add a walk over its N held entries (up to 128),
// which reads the slot memory at one entry per cycle.
// Reset (rst_n low at a clock edge) empties the queue and drops any pending
// result; slot contents are not cleared, so no clearing pass is needed.
module searchable_linear_queue
  import slq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [FLOOR_W-1:0] in_floor_num,
  input  logic               in_target_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [OUT_W-1:0]   out_floor,
  output logic               out_target,
  output logic               out_found,
  output logic               out_is_empty,
  output logic               out_is_full,
  output logic [OUT_W-1:0]   out_tail_floor
);

  slq_cmd_t cmd;
  slq_sts_t sts;

  slq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slq_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_floor_num   (in_floor_num),
    .in_target_in   (in_target_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_accepted   (out_accepted),
    .out_floor      (out_floor),
    .out_target     (out_target),
    .out_found      (out_found),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full),
    .out_tail_floor (out_tail_floor)
  );

endmodule

// ===== dv/searchable_linear_queue_tb.sv =====
module searchable_linear_queue_tb
  import slq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block does not know; they must leave the queue untouched
  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0] REQ_BAD_MID   = 3'd6;
  localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

  localparam logic [OUT_W-1:0] NO_FLOOR = '1;  // -1 at the output width

  localparam int unsigned ITEMS        = 1100;
  localparam int unsigned SETTLE_TICKS = 200;   // longest walk plus margin
  localparam int unsigned HOLD_START   = 3000;  // receiver cycle of the long hold-off
  localparam int unsigned HOLD_TICKS   = 400;
  localparam int unsigned CALM_START   = 8000;  // receiver never stalls in this window
  localparam int unsigned CALM_END     = 12000;

  // One result transaction, in port order
  typedef struct packed {
    logic             accepted;
    logic [OUT_W-1:0] floor_val;
    logic             target;
    logic             found;
    logic             empty;
    logic             full;
    logic [OUT_W-1:0] tail_floor;
  } queue_status_t;

  // Shadow of the floor queue plus the results still owed by the block
  class floor_queue_book;
    logic [FLOOR_W-1:0] slot_fl [DEPTH];
    logic               slot_tg [DEPTH];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    bit                 held;
    queue_status_t      owed[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        n_req [8];
    int unsigned        n_refused;
    int unsigned        n_deq_empty;
    int unsigned        n_walk_hits;

    function new();
      head_idx = 0;
      tail_idx = 0;
      held     = 1'b0;
      foreach (n_req[k]) n_req[k] = 0;
    endfunction

    function bit full_now();
      return held && tail_idx == DEPTH - 1;
    endfunction

    function bit empty_now();
      return !held;
    endfunction

    // Apply an accepted request; returns 0 when the block just ignores it
    function bit take_request(logic [2:0] rt, logic [FLOOR_W-1:0] fl, logic tg);
      queue_status_t want;
      bit            effective;
      int unsigned   i;
      want      = '0;
      effective = 1'b1;
      n_req[rt]++;
      case (rt)
        REQ_ENQ: begin
          if (!held) begin
            head_idx   = 0;
            tail_idx   = 0;
            held       = 1'b1;
            slot_fl[0] = fl;
            slot_tg[0] = tg;
            want.accepted = 1'b1;
          end else if (tail_idx < DEPTH - 1) begin
            // slots are not reused until the queue drains
            tail_idx++;
            slot_fl[tail_idx] = fl;
            slot_tg[tail_idx] = tg;
            want.accepted = 1'b1;
          end else begin
            effective = 1'b0;
            n_refused++;
          end
        end
        REQ_DEQ: begin
          if (!held) begin
            want.floor_val = NO_FLOOR;
            n_deq_empty++;
          end else begin
            want.accepted  = 1'b1;
            want.floor_val = {1'b0, slot_fl[head_idx]};
            want.target    = slot_tg[head_idx];
            if (head_idx >= tail_idx) begin
              head_idx = 0;
              tail_idx = 0;
              held     = 1'b0;
            end else begin
              head_idx++;
            end
          end
        end
        REQ_CLEAR: begin
          head_idx = 0;
          tail_idx = 0;
          held     = 1'b0;
        end
        REQ_MARK, REQ_SEARCH: begin
          // mark touches every match, search stops at the first
          if (held) begin
            for (i = head_idx; i <= tail_idx; i++) begin
              if (slot_fl[i] == fl) begin
                want.found = 1'b1;
                if (rt == REQ_MARK) slot_tg[i] = 1'b1;
                else break;
              end
            end
          end
          if (want.found) n_walk_hits++;
        end
        default: begin
          effective = 1'b0;
        end
      endcase
      want.empty      = !held;
      want.full       = full_now();
      want.tail_floor = held ? {1'b0, slot_fl[tail_idx]} : NO_FLOOR;
      owed.push_back(want);
      return effective;
    endfunction

    function void check_field(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
      end
    endfunction

    // Compare a result transaction with the oldest owed one
    function void compare_result(queue_status_t seen);
      queue_status_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, got %h",
                 $time, seen);
        return;
      end
      want = owed.pop_front();
      checked++;
      check_field("accepted",   OUT_W'(want.accepted), OUT_W'(seen.accepted));
      check_field("out_floor",  want.floor_val,        seen.floor_val);
      check_field("out_target", OUT_W'(want.target),   OUT_W'(seen.target));
      check_field("found",      OUT_W'(want.found),    OUT_W'(seen.found));
      check_field("is_empty",   OUT_W'(want.empty),    OUT_W'(seen.empty));
      check_field("is_full",    OUT_W'(want.full),     OUT_W'(seen.full));
      check_field("tail_floor", want.tail_floor,       seen.tail_floor);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_req_type = REQ_ENQ;
  logic [FLOOR_W-1:0] in_floor_num = '0;
  logic               in_target_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic [OUT_W-1:0]   out_floor;
  logic               out_target;
  logic               out_found;
  logic               out_is_empty;
  logic               out_is_full;
  logic [OUT_W-1:0]   out_tail_floor;

  floor_queue_book    book;
  logic [FLOOR_W-1:0] floor_pool [6];
  int unsigned        n_offered = 0;
  int unsigned        n_effective = 0;
  int unsigned        n_fill_rounds = 0;

  searchable_linear_queue uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Floors mostly come from a small pool so walks find matches
  function automatic logic [FLOOR_W-1:0] pick_floor();
    if ($urandom_range(0, 99) < 70) return floor_pool[$urandom_range(0, 5)];
    return FLOOR_W'($urandom);
  endfunction

  // Offer one request transaction and hold it until the block takes it
  task automatic offer_request(input logic [2:0] rt, input logic [FLOOR_W-1:0] fl,
                               input logic tg);
    if (!(n_offered >= 500 && n_offered < 650)) begin
      while ($urandom_range(0, 99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_req_type  <= rt;
    in_floor_num <= fl;
    in_target_in <= tg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_offered++;
    if (book.take_request(rt, fl, tg)) n_effective++;
  endtask

  // Weighted pick of one random request; whatever is left over is unknown codes
  task automatic offer_mix(input int unsigned enq_w, input int unsigned deq_w,
                           input int unsigned walk_w, input int unsigned clear_w);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_w)
      offer_request(REQ_ENQ, pick_floor(), 1'($urandom));
    else if (roll < enq_w + deq_w)
      offer_request(REQ_DEQ, FLOOR_W'($urandom), 1'($urandom));
    else if (roll < enq_w + deq_w + walk_w)
      offer_request($urandom_range(0, 1) ? REQ_MARK : REQ_SEARCH, pick_floor(),
                    1'($urandom));
    else if (roll < enq_w + deq_w + walk_w + clear_w)
      offer_request(REQ_CLEAR, FLOOR_W'($urandom), 1'($urandom));
    else
      offer_request(3'($urandom_range(REQ_BAD_FIRST, REQ_BAD_LAST)), FLOOR_W'($urandom),
                    1'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off, one quiet window
  initial begin : result_sink
    int unsigned tick;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick >= HOLD_START && tick < HOLD_START + HOLD_TICKS)
        out_stall <= 1'b1;
      else if (tick >= CALM_START && tick < CALM_END)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 31);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.compare_result({out_accepted, out_floor, out_target, out_found,
                           out_is_empty, out_is_full, out_tail_floor});
  end

  // Stimulus
  initial begin
    int unsigned burst;
    book = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-queue corners, both floor extremes, mark then drain
    offer_request(REQ_DEQ,    8'h00, 1'b0);
    offer_request(REQ_SEARCH, 8'h00, 1'b0);
    offer_request(REQ_MARK,   8'hFF, 1'b1);
    offer_request(REQ_ENQ,    8'h00, 1'b1);
    offer_request(REQ_ENQ,    8'hFF, 1'b0);
    offer_request(REQ_ENQ,    8'hAA, 1'b0);
    offer_request(REQ_SEARCH, 8'hFF, 1'b0);
    offer_request(REQ_SEARCH, 8'h55, 1'b1);
    offer_request(REQ_MARK,   8'hAA, 1'b0);
    offer_request(REQ_MARK,   8'h13, 1'b0);
    offer_request(REQ_DEQ,    8'hFF, 1'b1);
    offer_request(REQ_DEQ,    8'h00, 1'b0);
    offer_request(REQ_DEQ,    8'h00, 1'b0);
    offer_request(REQ_DEQ,    8'h00, 1'b0);
    offer_request(REQ_BAD_FIRST, 8'h55, 1'b1);
    offer_request(REQ_ENQ,    8'h55, 1'b1);
    offer_request(REQ_BAD_MID, 8'hFF, 1'b1);
    offer_request(REQ_BAD_LAST, 8'hAA, 1'b0);
    offer_request(REQ_CLEAR,  8'h55, 1'b1);
    offer_request(REQ_SEARCH, 8'h55, 1'b0);
    offer_request(REQ_ENQ,    8'h00, 1'b0);
    offer_request(REQ_CLEAR,  8'hFF, 1'b0);

    // random: fill-to-full rounds mixed with shallow bursts
    while (n_effective < ITEMS) begin
      foreach (floor_pool[k]) floor_pool[k] = FLOOR_W'($urandom);
      if (n_fill_rounds == 0 || $urandom_range(0, 3) == 0) begin
        n_fill_rounds++;
        while (!book.full_now()) offer_mix(78, 8, 12, 0);
        repeat (4) offer_request(REQ_ENQ, pick_floor(), 1'($urandom));
        while (!book.empty_now()) offer_mix(4, 76, 18, 0);
        offer_request(REQ_DEQ, FLOOR_W'($urandom), 1'($urandom));
      end else begin
        burst = $urandom_range(20, 60);
        repeat (burst) offer_mix(40, 30, 18, 4);
      end
    end
    in_valid <= 1'b0;

    // wait for every owed result, then watch for strays
    while (book.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d clear, %0d mark, %0d search",
             n_offered, book.n_req[REQ_ENQ], book.n_req[REQ_DEQ], book.n_req[REQ_CLEAR],
             book.n_req[REQ_MARK], book.n_req[REQ_SEARCH]);
    $display("%0d results checked, %0d fill rounds, %0d refused enqueues, %0d empty %s",
             book.checked, n_fill_rounds, book.n_refused, book.n_deq_empty, "dequeues");
    $display("%0d walks found a matching floor", book.n_walk_hits);
    if (book.errors == 0) begin
      $display("searchable_linear_queue_tb passed");
    end else begin
      $display("searchable_linear_queue_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("searchable_linear_queue_tb failed");
    $finish;
  end

endmodule
